// ----- src/imr_pkg.sv -----
`timescale 1ns / 1ps
// ============================================================================
// imr_pkg
// Shared types and constants of the image rescaler.
// ============================================================================
package imr_pkg;

    localparam int POS_W   = 10;
    localparam int PIX_W   = 32;
    localparam int SW_W    = 9;
    localparam int DW_W    = 11;
    localparam int PADDR_W = 5;
    localparam int PDATA_W = 32;
    localparam int PROD_W  = POS_W + SW_W;

    localparam int DEF_MAX_SRC_WIDTH  = 256;
    localparam int DEF_MAX_SRC_HEIGHT = 256;
    localparam int DEF_FRAC_BITS      = 8;

    localparam int RECIP3       = 683;
    localparam int RECIP3_SHIFT = 11;
    localparam int RECIP3_W     = 10;

    typedef enum logic [2:0] {
        REG_SRC_WIDTH  = 3'd0,
        REG_SRC_HEIGHT = 3'd1,
        REG_DST_WIDTH  = 3'd2,
        REG_DST_HEIGHT = 3'd3,
        REG_PIXEL_MODE = 3'd4
    } reg_idx_t;

    typedef enum logic [1:0] {
        MODE_INDEXED = 2'd0,
        MODE_RGB     = 2'd1,
        MODE_RGBA    = 2'd2
    } pix_mode_t;

    typedef enum logic {
        FUNC_WRITE = 1'b0,
        FUNC_READ  = 1'b1
    } func_t;

    typedef struct packed {
        func_t              func;
        logic [POS_W-1:0]   x;
        logic [POS_W-1:0]   y;
        logic [PIX_W-1:0]   data;
    } item_t;

endpackage

// ----- src/imr_div.sv -----
`timescale 1ns / 1ps
// ============================================================================
// imr_div
// Pipelined restoring divider, one quotient bit per stage.
// ============================================================================
module imr_div #(
    parameter int NW  = 27,
    parameter int QW  = 16,
    parameter int DVW = 11
) (
    input  logic           clk,
    input  logic           en,
    input  logic [NW-1:0]  num,
    input  logic [DVW-1:0] den,
    output logic [QW-1:0]  quo
);

    logic [DVW-1:0] rem_reg  [QW];
    logic [QW-1:0]  low_reg  [QW];
    logic [QW-1:0]  q_reg    [QW];
    logic [DVW-1:0] rem_next [QW];
    logic [QW-1:0]  low_next [QW];
    logic [QW-1:0]  q_next   [QW];

    for (genvar k = 0; k < QW; k++) begin : g_stage
        logic [DVW-1:0] rem_src;
        logic [QW-1:0]  low_src;
        logic [QW-1:0]  q_src;
        logic [DVW:0]   trial;

        if (k == 0) begin : g_first
            assign rem_src = DVW'(num[NW-1:QW]);
            assign low_src = num[QW-1:0];
            assign q_src   = '0;
        end else begin : g_next
            assign rem_src = rem_reg[k-1];
            assign low_src = low_reg[k-1];
            assign q_src   = q_reg[k-1];
        end

        always_comb
        begin
            trial       = {rem_src, low_src[QW-1]};
            low_next[k] = {low_src[QW-2:0], 1'b0};
            if (trial >= {1'b0, den})
            begin
                rem_next[k] = DVW'(trial - {1'b0, den});
                q_next[k]   = {q_src[QW-2:0], 1'b1};
            end
            else
            begin
                rem_next[k] = trial[DVW-1:0];
                q_next[k]   = {q_src[QW-2:0], 1'b0};
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg[k] <= rem_next[k];
                low_reg[k] <= low_next[k];
                q_reg[k]   <= q_next[k];
            end
        end
    end

    assign quo = q_reg[QW-1];

endmodule

// ----- src/image_rescaler.sv -----
`timescale 1ns / 1ps
// ============================================================================
// image_rescaler
// Source image store with nearest and bilinear style scaled readout.
// ============================================================================
// Takes one transfer per cycle, writes and reads alike, as long as the output
// is not stalled. A read result passes through the input multiply register,
// the divider stages, the bank read register, the blend register and the
// output register; the two pipelined coordinate dividers make up most of that
// path. The image lives in four single-port banks split by row and column
// parity, so the four neighbours of a pixel are read together from the banks.
// Writes give no result and take effect in order with the reads around them.
module image_rescaler
    import imr_pkg::*;
#(
    parameter int MAX_SRC_WIDTH  = DEF_MAX_SRC_WIDTH,
    parameter int MAX_SRC_HEIGHT = DEF_MAX_SRC_HEIGHT,
    parameter int FRAC_BITS      = DEF_FRAC_BITS
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [PDATA_W-1:0] pwdata,
    output logic [PDATA_W-1:0] prdata,
    output logic               pready,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic               func,
    input  logic [POS_W-1:0]   pos_x,
    input  logic [POS_W-1:0]   pos_y,
    input  logic [PIX_W-1:0]   pixel_in,
    output logic               out_valid,
    input  logic               out_stall,
    output logic [PIX_W-1:0]   pixel_out
);

    localparam int IXW   = $clog2(MAX_SRC_WIDTH);
    localparam int IYW   = $clog2(MAX_SRC_HEIGHT);
    localparam int IMW   = (IXW > IYW) ? IXW : IYW;
    localparam int QW    = IMW + FRAC_BITS;
    localparam int NW    = PROD_W + FRAC_BITS;
    localparam int ADW   = (IXW - 1) + (IYW - 1);
    localparam int BANK_DEPTH = (MAX_SRC_WIDTH * MAX_SRC_HEIGHT) / 4;
    localparam int WW    = FRAC_BITS + 2;
    localparam int AW    = FRAC_BITS + 10;
    localparam int ONE3  = 3 * (1 << FRAC_BITS);
    localparam int HALF3 = ONE3 / 2;
    localparam int TW    = 10;
    localparam int RPW   = TW + RECIP3_W;

    // configuration
    logic [SW_W-1:0] src_width_reg;
    logic [SW_W-1:0] src_height_reg;
    logic [DW_W-1:0] dst_width_reg;
    logic [DW_W-1:0] dst_height_reg;
    pix_mode_t       pixel_mode_reg;
    logic            cfg_wr;
    reg_idx_t        cfg_idx;

    assign pready  = 1'b1;
    assign cfg_wr  = psel & penable & pwrite & pready;
    assign cfg_idx = reg_idx_t'(paddr[4:2]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            src_width_reg  <= SW_W'(256);
            src_height_reg <= SW_W'(256);
            dst_width_reg  <= DW_W'(256);
            dst_height_reg <= DW_W'(256);
            pixel_mode_reg <= MODE_RGBA;
        end
        else if (cfg_wr)
        begin
            unique case (cfg_idx)
                REG_SRC_WIDTH:  src_width_reg  <= pwdata[SW_W-1:0];
                REG_SRC_HEIGHT: src_height_reg <= pwdata[SW_W-1:0];
                REG_DST_WIDTH:  dst_width_reg  <= pwdata[DW_W-1:0];
                REG_DST_HEIGHT: dst_height_reg <= pwdata[DW_W-1:0];
                REG_PIXEL_MODE: pixel_mode_reg <= pix_mode_t'(pwdata[1:0]);
                default: ;
            endcase
        end
    end

    always_comb
    begin
        unique case (cfg_idx)
            REG_SRC_WIDTH:  prdata = PDATA_W'(src_width_reg);
            REG_SRC_HEIGHT: prdata = PDATA_W'(src_height_reg);
            REG_DST_WIDTH:  prdata = PDATA_W'(dst_width_reg);
            REG_DST_HEIGHT: prdata = PDATA_W'(dst_height_reg);
            REG_PIXEL_MODE: prdata = PDATA_W'(pixel_mode_reg);
            default:        prdata = '0;
        endcase
    end

    // effective sizes
    logic [SW_W-1:0] sw_eff;
    logic [SW_W-1:0] sh_eff;
    logic [DW_W-1:0] dw_eff;
    logic [DW_W-1:0] dh_eff;

    always_comb
    begin
        if (src_width_reg == '0)
            sw_eff = SW_W'(1);
        else if (int'(src_width_reg) > MAX_SRC_WIDTH)
            sw_eff = SW_W'(MAX_SRC_WIDTH);
        else
            sw_eff = src_width_reg;
        if (src_height_reg == '0)
            sh_eff = SW_W'(1);
        else if (int'(src_height_reg) > MAX_SRC_HEIGHT)
            sh_eff = SW_W'(MAX_SRC_HEIGHT);
        else
            sh_eff = src_height_reg;
        dw_eff = (dst_width_reg == '0) ? DW_W'(1) : dst_width_reg;
        dh_eff = (dst_height_reg == '0) ? DW_W'(1) : dst_height_reg;
    end

    // pipeline advance
    logic out_valid_reg;
    logic adv;

    assign adv      = !out_valid_reg || !out_stall;
    assign in_stall = !adv;

    // input stage: clamp and multiply
    logic [POS_W-1:0]  px_c;
    logic [POS_W-1:0]  py_c;
    logic [PROD_W-1:0] prodx_reg;
    logic [PROD_W-1:0] prody_reg;
    logic [PROD_W-1:0] prodx_next;
    logic [PROD_W-1:0] prody_next;

    always_comb
    begin
        px_c = ({1'b0, pos_x} >= dw_eff) ? POS_W'(dw_eff - DW_W'(1)) : pos_x;
        py_c = ({1'b0, pos_y} >= dh_eff) ? POS_W'(dh_eff - DW_W'(1)) : pos_y;
        prodx_next = PROD_W'(px_c) * PROD_W'(sw_eff);
        prody_next = PROD_W'(py_c) * PROD_W'(sh_eff);
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            prodx_reg <= prodx_next;
            prody_reg <= prody_next;
        end
    end

    // side line aligned with the dividers
    logic  side_valid_reg [QW+1];
    item_t side_item_reg  [QW+1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k <= QW; k++)
                side_valid_reg[k] <= 1'b0;
        end
        else if (adv)
        begin
            side_valid_reg[0] <= in_valid;
            for (int k = 1; k <= QW; k++)
                side_valid_reg[k] <= side_valid_reg[k-1];
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            side_item_reg[0] <= '{func: func_t'(func), x: pos_x, y: pos_y, data: pixel_in};
            for (int k = 1; k <= QW; k++)
                side_item_reg[k] <= side_item_reg[k-1];
        end
    end

    logic [QW-1:0] qx;
    logic [QW-1:0] qy;

    imr_div #(.NW(NW), .QW(QW), .DVW(DW_W)) u_div_x (
        .clk (clk),
        .en  (adv),
        .num ({prodx_reg, FRAC_BITS'(0)}),
        .den (dw_eff),
        .quo (qx)
    );

    imr_div #(.NW(NW), .QW(QW), .DVW(DW_W)) u_div_y (
        .clk (clk),
        .en  (adv),
        .num ({prody_reg, FRAC_BITS'(0)}),
        .den (dh_eff),
        .quo (qy)
    );

    // memory stage
    item_t                mi;
    logic                 mv;
    logic [IXW-1:0]       ix;
    logic [IYW-1:0]       iy;
    logic [IXW-1:0]       ix1;
    logic [IYW-1:0]       iy1;
    logic [FRAC_BITS-1:0] fx;
    logic [FRAC_BITS-1:0] fy;
    logic                 last_row;
    logic                 last_col;
    logic [IXW-1:0]       wx;
    logic [IYW-1:0]       wy;
    logic                 wr_ok;
    logic                 rd_go;
    logic [PIX_W-1:0]     bank_rd [4];

    always_comb
    begin
        mi       = side_item_reg[QW];
        mv       = side_valid_reg[QW];
        ix       = qx[IXW+FRAC_BITS-1:FRAC_BITS];
        iy       = qy[IYW+FRAC_BITS-1:FRAC_BITS];
        ix1      = ix + IXW'(1);
        iy1      = iy + IYW'(1);
        fx       = qx[FRAC_BITS-1:0];
        fy       = qy[FRAC_BITS-1:0];
        last_row = int'(iy) == int'(sh_eff) - 1;
        last_col = int'(ix) == int'(sw_eff) - 1;
        wx       = IXW'(mi.x);
        wy       = IYW'(mi.y);
        wr_ok    = adv && mv && (mi.func == FUNC_WRITE)
                   && (int'(mi.x) < MAX_SRC_WIDTH) && (int'(mi.y) < MAX_SRC_HEIGHT);
        rd_go    = adv && mv && (mi.func == FUNC_READ);
    end

    for (genvar b = 0; b < 4; b++) begin : g_bank
        localparam logic BX = 1'(b % 2);
        localparam logic BY = 1'(b / 2);

        logic [PIX_W-1:0] bank_mem [BANK_DEPTH];
        logic [PIX_W-1:0] rd_reg;
        logic [ADW-1:0]   rd_addr;
        logic [ADW-1:0]   wr_addr;
        logic             wr_en;

        always_comb
        begin
            rd_addr = {(BY == iy[0]) ? iy[IYW-1:1] : iy1[IYW-1:1],
                       (BX == ix[0]) ? ix[IXW-1:1] : ix1[IXW-1:1]};
            wr_addr = {wy[IYW-1:1], wx[IXW-1:1]};
            wr_en   = wr_ok && (wy[0] == BY) && (wx[0] == BX);
        end

        always_ff @(posedge clk)
        begin
            if (wr_en)
                bank_mem[wr_addr] <= mi.data;
            else if (rd_go)
                rd_reg <= bank_mem[rd_addr];
        end

        assign bank_rd[b] = rd_reg;
    end

    logic                 m_valid_reg;
    logic [FRAC_BITS-1:0] m_fx_reg;
    logic [FRAC_BITS-1:0] m_fy_reg;
    logic                 m_lr_reg;
    logic                 m_lc_reg;
    logic                 m_xp_reg;
    logic                 m_yp_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            m_valid_reg <= 1'b0;
        else if (adv)
            m_valid_reg <= mv && (mi.func == FUNC_READ);
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            m_fx_reg <= fx;
            m_fy_reg <= fy;
            m_lr_reg <= last_row;
            m_lc_reg <= last_col;
            m_xp_reg <= ix[0];
            m_yp_reg <= iy[0];
        end
    end

    // blend stage
    logic [PIX_W-1:0]     p1;
    logic [PIX_W-1:0]     p2;
    logic [PIX_W-1:0]     p3;
    logic [PIX_W-1:0]     p4;
    logic [FRAC_BITS:0]   fsum;
    logic [FRAC_BITS-1:0] fz;
    logic [WW-1:0]        w1;
    logic [AW-1:0]        acc_next [4];
    logic [AW-1:0]        acc_reg  [4];
    logic [7:0]           a_idx_reg;
    logic                 a_valid_reg;

    always_comb
    begin
        p1 = bank_rd[{m_yp_reg, m_xp_reg}];
        p2 = m_lr_reg ? p1 : bank_rd[{~m_yp_reg, m_xp_reg}];
        p3 = m_lc_reg ? p1 : bank_rd[{m_yp_reg, ~m_xp_reg}];
        p4 = (m_lr_reg || m_lc_reg) ? p1 : bank_rd[{~m_yp_reg, ~m_xp_reg}];
        fsum = {1'b0, m_fx_reg} + {1'b0, m_fy_reg};
        fz   = fsum[FRAC_BITS:1];
        w1   = WW'(ONE3) - WW'(m_fx_reg) - WW'(m_fy_reg) - WW'(fz);
        for (int c = 0; c < 4; c++)
            acc_next[c] = AW'(p1[8*c +: 8]) * AW'(w1)
                        + AW'(p2[8*c +: 8]) * AW'(m_fy_reg)
                        + AW'(p3[8*c +: 8]) * AW'(m_fx_reg)
                        + AW'(p4[8*c +: 8]) * AW'(fz);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            a_valid_reg <= 1'b0;
        else if (adv)
            a_valid_reg <= m_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            acc_reg   <= acc_next;
            a_idx_reg <= p1[7:0];
        end
    end

    // normalize and output
    logic [AW-1:0]    rnd   [4];
    logic [TW-1:0]    tq    [4];
    logic [RPW-1:0]   rp    [4];
    logic [7:0]       ch    [4];
    logic [PIX_W-1:0] pixel_next;
    logic [PIX_W-1:0] pixel_out_reg;

    always_comb
    begin
        for (int c = 0; c < 4; c++)
        begin
            rnd[c] = acc_reg[c] + AW'(HALF3);
            tq[c]  = TW'(rnd[c] >> FRAC_BITS);
            rp[c]  = RPW'(tq[c]) * RPW'(RECIP3);
            ch[c]  = (rp[c] >> RECIP3_SHIFT) > RPW'(255) ? 8'hFF
                                                          : 8'(rp[c] >> RECIP3_SHIFT);
        end
        case (pixel_mode_reg)
            MODE_INDEXED: pixel_next = {24'b0, a_idx_reg};
            MODE_RGB:     pixel_next = {8'b0, ch[2], ch[1], ch[0]};
            default:      pixel_next = {ch[3], ch[2], ch[1], ch[0]};
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (adv)
            out_valid_reg <= a_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
            pixel_out_reg <= pixel_next;
    end

    assign out_valid = out_valid_reg;
    assign pixel_out = pixel_out_reg;

endmodule

// ----- src/imr_checker.sv -----
`timescale 1ns / 1ps
// ============================================================================
// imr_checker
// Port-level checks of the image rescaler transfer channels.
// ============================================================================
module imr_checker
    import imr_pkg::*;
(
    input logic             clk,
    input logic             rst_n,
    input logic             in_valid,
    input logic             in_stall,
    input logic             out_valid,
    input logic             out_stall,
    input logic [PIX_W-1:0] pixel_out
);

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(pixel_out))
        else $error("result changed while stalled");

    a_back_pressure: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |-> in_stall)
        else $error("input taken while output blocked");

    a_free_flow: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid |-> !in_stall)
        else $error("input stalled with empty output");

    a_no_stall_drop: assert property (@(posedge clk) disable iff (!rst_n)
        !out_stall |-> !in_stall)
        else $error("input stalled without output stall");

endmodule

bind image_rescaler imr_checker u_imr_checker (.*);

// ----- verif/tb_top.sv -----
`timescale 1ns / 1ps
// ============================================================================
// tb_top
// Self-checking testbench for the image rescaler.
// ============================================================================
// Each phase programs the size and mode registers over APB, fills the used
// source area, then streams a mix of pixel writes and scaled reads. A local
// model of the pixel store and the scaling arithmetic predicts every read
// result. A monitor compares each output transfer with the oldest prediction.
// Both channels idle in random bursts outside the last two phases, and two
// phases hold the output off long enough to back up the input.
module tb_top;
    import imr_pkg::*;

    localparam int STORE_W      = 256;
    localparam int STORE_H      = 256;
    localparam int ONE          = 256;
    localparam int WATCH_LIMIT  = 20000;
    localparam int DRAIN_CYCLES = 40;
    localparam int HOLD_CYCLES  = 300;
    localparam int PHASES       = 12;

    logic               clk;
    logic               rst_n;
    logic               psel;
    logic               penable;
    logic               pwrite;
    logic [PADDR_W-1:0] paddr;
    logic [PDATA_W-1:0] pwdata;
    logic [PDATA_W-1:0] prdata;
    logic               pready;
    logic               in_valid;
    logic               in_stall;
    logic               func;
    logic [POS_W-1:0]   pos_x;
    logic [POS_W-1:0]   pos_y;
    logic [PIX_W-1:0]   pixel_in;
    logic               out_valid;
    logic               out_stall;
    logic [PIX_W-1:0]   pixel_out;

    image_rescaler DUT (
        .clk(clk), .rst_n(rst_n),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready),
        .in_valid(in_valid), .in_stall(in_stall),
        .func(func), .pos_x(pos_x), .pos_y(pos_y), .pixel_in(pixel_in),
        .out_valid(out_valid), .out_stall(out_stall), .pixel_out(pixel_out)
    );

    item_t       pixel_q[$];
    logic [31:0] scaled_q[$];
    logic [31:0] src_img [0:STORE_W*STORE_H-1];

    logic [8:0]  cfg_sw;
    logic [8:0]  cfg_sh;
    logic [10:0] cfg_dw;
    logic [10:0] cfg_dh;
    logic [1:0]  cfg_mode;

    int  errors;
    int  quiet_cycles;
    bit  calm;
    bit  in_took;
    int  in_gap;
    int  out_gap;
    int  hold_reqs;
    int  hold_done;
    int  hold_left;

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("mismatch: %s got %08h want %08h", what, got, want);
        errors++;
    endtask

    function automatic int unsigned eff_size(input int unsigned v, input int unsigned maxv);
        if (v == 0)
            return 1;
        if (v > maxv)
            return maxv;
        return v;
    endfunction

    function automatic logic [7:0] blend(input int unsigned p1, p2, p3, p4,
                                         input int unsigned fx, fy, fz);
        longint unsigned acc;
        longint unsigned r;
        acc = p1 * (ONE - fy) + p2 * fy + p1 * (ONE - fx) + p3 * fx
            + p1 * (ONE - fz) + p4 * fz;
        r = (acc + 3 * ONE / 2) / (3 * ONE);
        return (r > 255) ? 8'hFF : r[7:0];
    endfunction

    function automatic logic [31:0] scaled_pixel(input int unsigned px, input int unsigned py);
        int unsigned sw, sh, dw, dh, ix, iy, fx, fy, fz, nch;
        logic [31:0] p1, p2, p3, p4, res;
        bit last_row, last_col;
        sw = eff_size(cfg_sw, STORE_W);
        sh = eff_size(cfg_sh, STORE_H);
        dw = eff_size(cfg_dw, 2047);
        dh = eff_size(cfg_dh, 2047);
        if (px >= dw)
            px = dw - 1;
        if (py >= dh)
            py = dh - 1;
        ix = (px * sw) / dw;
        fx = (((px * sw) % dw) * ONE) / dw;
        iy = (py * sh) / dh;
        fy = (((py * sh) % dh) * ONE) / dh;
        p1 = src_img[iy*STORE_W + ix];
        if (cfg_mode == MODE_INDEXED)
            return {24'd0, p1[7:0]};
        fz = (fx + fy) / 2;
        last_row = (iy == sh - 1);
        last_col = (ix == sw - 1);
        p2 = last_row ? p1 : src_img[(iy+1)*STORE_W + ix];
        p3 = last_col ? p1 : src_img[iy*STORE_W + ix + 1];
        p4 = (last_row || last_col) ? p1 : src_img[(iy+1)*STORE_W + ix + 1];
        nch = (cfg_mode == MODE_RGB) ? 3 : 4;
        res = '0;
        for (int k = 0; k < nch; k++)
            res[8*k +: 8] = blend(p1[8*k +: 8], p2[8*k +: 8], p3[8*k +: 8], p4[8*k +: 8],
                                  fx, fy, fz);
        return res;
    endfunction

    // sample both channels, predict, and check
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            in_took <= in_valid && !in_stall;
            if (in_valid && !in_stall)
            begin
                if (func == FUNC_WRITE)
                begin
                    if (pos_x < STORE_W && pos_y < STORE_H)
                        src_img[pos_y*STORE_W + pos_x] = pixel_in;
                end
                else
                    scaled_q.push_back(scaled_pixel(pos_x, pos_y));
            end
            if (out_valid && !out_stall)
            begin
                if (scaled_q.size() == 0)
                    report_mismatch("unexpected pixel_out", pixel_out, '0);
                else if (pixel_out !== scaled_q[0])
                    report_mismatch("pixel_out", pixel_out, scaled_q.pop_front());
                else
                    void'(scaled_q.pop_front());
            end
            if ((in_valid && !in_stall) || (out_valid && !out_stall))
                quiet_cycles <= 0;
            else
                quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= WATCH_LIMIT)
            begin
                $display("tb_top failed");
                $finish;
            end
        end
    end

    // input driver
    always @(negedge clk)
    begin
        if (rst_n && (!in_valid || in_took))
        begin
            if (in_gap > 0)
            begin
                in_valid <= 1'b0;
                in_gap <= in_gap - 1;
            end
            else if (!calm && $urandom_range(0, 7) == 0)
            begin
                in_valid <= 1'b0;
                in_gap <= $urandom_range(0, 5);
            end
            else if (pixel_q.size() > 0)
            begin
                item_t it;
                it = pixel_q.pop_front();
                func <= it.func;
                pos_x <= it.x;
                pos_y <= it.y;
                pixel_in <= it.data;
                in_valid <= 1'b1;
            end
            else
                in_valid <= 1'b0;
        end
    end

    // output stall
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (hold_reqs != hold_done)
            begin
                hold_done <= hold_reqs;
                hold_left <= HOLD_CYCLES;
                out_stall <= 1'b1;
            end
            else if (hold_left > 0)
            begin
                hold_left <= hold_left - 1;
                out_stall <= 1'b1;
            end
            else if (out_gap > 0)
            begin
                out_gap <= out_gap - 1;
                out_stall <= 1'b1;
            end
            else if (!calm && $urandom_range(0, 7) == 0)
            begin
                out_gap <= $urandom_range(0, 5);
                out_stall <= 1'b1;
            end
            else
                out_stall <= 1'b0;
        end
    end

    task automatic apb_write(input reg_idx_t idx, input logic [31:0] value);
        @(negedge clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= PADDR_W'(int'(idx) * 4);
        pwdata <= value;
        @(negedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        case (idx)
            REG_SRC_WIDTH:  cfg_sw = value[8:0];
            REG_SRC_HEIGHT: cfg_sh = value[8:0];
            REG_DST_WIDTH:  cfg_dw = value[10:0];
            REG_DST_HEIGHT: cfg_dh = value[10:0];
            default:        cfg_mode = value[1:0];
        endcase
        @(negedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
    endtask

    task automatic push_pixel(input func_t f, input int unsigned x, input int unsigned y,
                              input logic [31:0] data);
        item_t it;
        it.func = f;
        it.x = x[POS_W-1:0];
        it.y = y[POS_W-1:0];
        it.data = data;
        pixel_q.push_back(it);
    endtask

    task automatic wait_idle();
        do
            @(posedge clk);
        while (pixel_q.size() > 0 || in_valid || scaled_q.size() > 0);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    initial
    begin
        int unsigned sw, sh, dw, dh, n;
        logic [31:0] v_sw, v_sh, v_dw, v_dh, v_mode;
        rst_n = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        in_valid = 1'b0;
        func = FUNC_WRITE;
        pos_x = '0;
        pos_y = '0;
        pixel_in = '0;
        out_stall = 1'b0;
        errors = 0;
        quiet_cycles = 0;
        calm = 1'b0;
        in_took = 1'b0;
        in_gap = 0;
        out_gap = 0;
        hold_reqs = 0;
        hold_done = 0;
        hold_left = 0;
        cfg_sw = 9'd256;
        cfg_sh = 9'd256;
        cfg_dw = 11'd256;
        cfg_dh = 11'd256;
        cfg_mode = MODE_RGBA;
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        for (int ph = 0; ph < PHASES; ph++)
        begin
            case (ph)
                0:       begin v_sw = 4;   v_sh = 3;   v_dw = 9;    v_dh = 7;    v_mode = MODE_RGB; end
                1:       begin v_sw = 0;   v_sh = 0;   v_dw = 0;    v_dh = 0;    v_mode = MODE_INDEXED; end
                2:       begin v_sw = 256; v_sh = 1;   v_dw = 1024; v_dh = 2;    v_mode = MODE_RGBA; end
                3:       begin v_sw = 1;   v_sh = 511; v_dw = 2047; v_dh = 1;    v_mode = 3; end
                4:       begin v_sw = 16;  v_sh = 16;  v_dw = 1;    v_dh = 1024; v_mode = MODE_INDEXED; end
                default:
                begin
                    v_sw = $urandom_range(1, 16);
                    v_sh = $urandom_range(1, 16);
                    v_dw = $urandom_range(0, 1) ? $urandom_range(1, 40) : $urandom_range(1, 1024);
                    v_dh = $urandom_range(0, 1) ? $urandom_range(1, 40) : $urandom_range(1, 1024);
                    v_mode = $urandom_range(0, 3);
                end
            endcase
            calm = (ph >= PHASES - 2);
            apb_write(REG_SRC_WIDTH, v_sw);
            apb_write(REG_SRC_HEIGHT, v_sh);
            apb_write(REG_DST_WIDTH, v_dw);
            apb_write(REG_DST_HEIGHT, v_dh);
            apb_write(REG_PIXEL_MODE, v_mode);
            sw = eff_size(cfg_sw, STORE_W);
            sh = eff_size(cfg_sh, STORE_H);
            dw = eff_size(cfg_dw, 2047);
            dh = eff_size(cfg_dh, 2047);

            for (int y = 0; y < sh; y++)
                for (int x = 0; x < sw; x++)
                    push_pixel(FUNC_WRITE, x, y, $urandom());

            if (ph == 0)
            begin
                push_pixel(FUNC_WRITE, 0, 0, 32'hFFFF_FFFF);
                push_pixel(FUNC_WRITE, 3, 2, 32'h0000_0000);
                push_pixel(FUNC_WRITE, 1023, 0, 32'hFFFF_FFFF);
                push_pixel(FUNC_WRITE, 0, 1023, 32'hFFFF_FFFF);
                push_pixel(FUNC_WRITE, 1023, 1023, 32'h0);
                push_pixel(FUNC_READ, 0, 0, 32'h0);
                push_pixel(FUNC_READ, dw - 1, dh - 1, 32'hFFFF_FFFF);
                push_pixel(FUNC_READ, 1023, 1023, 32'h0);
                push_pixel(FUNC_READ, 1023, 0, 32'h0);
                push_pixel(FUNC_READ, 0, 1023, 32'h0);
                push_pixel(FUNC_READ, dw / 2, dh / 2, 32'h0);
            end

            if (ph == 2 || ph == 6)
                hold_reqs++;

            n = (ph < 4) ? 40 : 30;
            for (int i = 0; i < n; i++)
            begin
                case ($urandom_range(0, 9))
                    0, 1:
                        push_pixel(FUNC_WRITE, $urandom_range(0, sw - 1),
                                   $urandom_range(0, sh - 1), $urandom());
                    2:
                        push_pixel(FUNC_WRITE, $urandom_range(0, 1023),
                                   $urandom_range(0, 1023), $urandom());
                    3:
                        push_pixel(FUNC_READ, $urandom_range(0, 1023),
                                   $urandom_range(0, 1023), $urandom());
                    default:
                        push_pixel(FUNC_READ, $urandom_range(0, dw > 1024 ? 1023 : dw - 1),
                                   $urandom_range(0, dh > 1024 ? 1023 : dh - 1), $urandom());
                endcase
            end
            wait_idle();
        end

        if (errors == 0)
            $display("tb_top passed");
        else
            $display("tb_top failed");
        $finish;
    end

endmodule

// ----- sim.f -----
src/imr_pkg.sv
src/imr_div.sv
src/image_rescaler.sv
src/imr_checker.sv
verif/tb_top.sv
